>>> sv/rtttl_note_parser_macros.svh
// Assertion macros shared by the ringtone parser modules.
// Each expects a clock named clk in scope; RTP_ASSERT also expects an active-low reset named rst_n.
`ifndef RTTTL_NOTE_PARSER_MACROS_SVH
`define RTTTL_NOTE_PARSER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RTP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RTP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/rtp_pkg.sv
// Types, codes and constants for the ringtone parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package rtp_pkg;

  localparam int NUM_W  = 16;
  localparam int DUR_W  = 19;
  localparam int NOTE_W = 4;
  localparam int OCT_W  = 4;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int DIV_STEPS = DUR_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam logic [DUR_W-1:0]  MS_PER_MIN    = DUR_W'(60000);
  localparam logic [DUR_W-1:0]  WHOLE_RST     = DUR_W'(3808);
  localparam logic [NUM_W-1:0]  DEF_LEN_RST   = NUM_W'(4);
  localparam logic [OCT_W-1:0]  DEF_OCT_RST   = OCT_W'(6);
  localparam logic [NUM_W-1:0]  NUM_MAX       = {NUM_W{1'b1}};
  localparam logic [NUM_W-1:0]  OCT_LO        = NUM_W'(3);
  localparam logic [NUM_W-1:0]  OCT_HI        = NUM_W'(7);
  localparam logic [NUM_W-1:0]  OCT_SAT       = NUM_W'(15);

  typedef struct packed {
    logic       action;
    logic [7:0] ch;
  } in_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [OCT_W-1:0]  octave;
    logic [DUR_W-1:0]  duration_ms;
    logic              song_end;
  } out_t;

  typedef enum logic [2:0] {
    CC_NUL,
    CC_COLON,
    CC_COMMA,
    CC_SPACE,
    CC_HASH,
    CC_DOT,
    CC_DIGIT,
    CC_OTHER
  } ch_class_t;

  typedef enum logic [1:0] {
    KEY_NONE,
    KEY_D,
    KEY_O,
    KEY_B
  } key_t;

  typedef enum logic [3:0] {
    PH_NAME,
    PH_HKEY,
    PH_HVAL,
    PH_NDUR,
    PH_NLET,
    PH_NSHARP,
    PH_NDOT,
    PH_NOCT,
    PH_NOCTDOT,
    PH_NDONE,
    PH_END
  } phase_t;

  typedef enum logic {
    ENG_RUN,
    ENG_WAIT
  } eng_state_t;

  typedef enum logic {
    DST_TEMPO,
    DST_NOTE
  } div_dst_t;

  // One classified character as it sits in the queue.
  typedef struct packed {
    logic              restart;
    ch_class_t         cls;
    key_t              key;
    logic [NOTE_W-1:0] letter;
    logic [3:0]        digit;
  } q_entry_t;

  typedef struct packed {
    logic             start;
    logic [DUR_W-1:0] dividend;
    logic [NUM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DUR_W-1:0] quotient;
  } div_rsp_t;

  // Append one decimal digit, saturating at the top of the number range.
  function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] acc,
                                                 input logic [3:0] d);
    logic [NUM_W+3:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {(NUM_W)'(0), d};
    return (v > {4'b0000, NUM_MAX}) ? NUM_MAX : v[NUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/rtttl_note_parser.sv
// Ringtone text parser: top level joining front queue, back-end parser and divider.
// Depends on rtp_pkg, rtp_front, rtp_back and rtp_div.
`default_nettype none

// Takes RTTTL ringtone text one character word at a time and returns one word
// per note (note, octave, length in ms) or a song_end word at the terminator.
// Characters enter a four-word queue and are taken by the back end at one per
// cycle while it is not waiting on the divider and the output is not held. A
// separator that closes a 'b=' header item with a nonzero value and every
// character that opens a note start the shared restoring divider, and the back
// end takes no further character until the quotient is back.
// A result waits in the output register while further characters are queued.
// action = 1 restarts the parser with default settings and gives no result.
module rtttl_note_parser import rtp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic      q_valid;
  logic      q_pop;
  q_entry_t  q_entry;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  rtp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_entry  (q_entry)
  );

  rtp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rtp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_entry   (q_entry),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> sv/rtp_front.sv
// Front end: classifies each incoming character and holds it in a short queue.
// Depends on rtp_pkg.
`default_nettype none

module rtp_front import rtp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_t      in_data,
  output logic          q_valid,
  input  wire logic     q_pop,
  output q_entry_t      q_entry
);

  q_entry_t            q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]     cnt_r, cnt_nxt;
  logic                push;
  q_entry_t            cls_entry;

  always_comb begin
    cls_entry         = '0;
    cls_entry.restart = in_data.action;
    cls_entry.digit   = in_data.ch[3:0];
    case (in_data.ch)
      8'h00:   cls_entry.cls = CC_NUL;
      ":":     cls_entry.cls = CC_COLON;
      ",":     cls_entry.cls = CC_COMMA;
      " ":     cls_entry.cls = CC_SPACE;
      "#":     cls_entry.cls = CC_HASH;
      ".":     cls_entry.cls = CC_DOT;
      default: cls_entry.cls = (in_data.ch inside {["0":"9"]}) ? CC_DIGIT : CC_OTHER;
    endcase
    case (in_data.ch)
      "d":     cls_entry.key = KEY_D;
      "o":     cls_entry.key = KEY_O;
      "b":     cls_entry.key = KEY_B;
      default: cls_entry.key = KEY_NONE;
    endcase
    case (in_data.ch)
      "c":     cls_entry.letter = NOTE_W'(1);
      "d":     cls_entry.letter = NOTE_W'(3);
      "e":     cls_entry.letter = NOTE_W'(5);
      "f":     cls_entry.letter = NOTE_W'(6);
      "g":     cls_entry.letter = NOTE_W'(8);
      "a":     cls_entry.letter = NOTE_W'(10);
      "b":     cls_entry.letter = NOTE_W'(12);
      default: cls_entry.letter = NOTE_W'(0);
    endcase
  end

  assign in_stall = (cnt_r == Q_CW'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != Q_CW'(0));
  assign q_entry  = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CW'(push) - Q_CW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_entry;
    end
  end

`include "rtttl_note_parser_macros.svh"

  `RTP_ASSERT(a_q_no_overfill, cnt_r <= Q_CW'(Q_DEPTH), "queue count beyond depth")
  `RTP_ASSERT(a_q_pop_nonempty, q_pop |-> q_valid, "word popped from empty queue")

endmodule

`default_nettype wire

>>> sv/rtp_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rtp_pkg.
`default_nettype none

module rtp_div import rtp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [DIV_CW-1:0]   cnt_r, cnt_nxt;
  logic [NUM_W-1:0]    rem_r, rem_nxt;
  logic [NUM_W-1:0]    dvs_r, dvs_nxt;
  logic [DUR_W-1:0]    quo_r, quo_nxt;
  logic [NUM_W:0]      trial;
  logic [NUM_W:0]      diff;
  logic                ge;

  // quo_r shifts the dividend out at the top and the quotient in at the bottom
  assign trial = {rem_r, quo_r[DUR_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      quo_nxt  = req.dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
      quo_nxt = {quo_r[DUR_W-2:0], ge};
      cnt_nxt = cnt_r + DIV_CW'(1);
      if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

`include "rtttl_note_parser_macros.svh"

  `RTP_ASSERT(a_div_done_after_busy, done_r |-> $past(busy_r), "divider done without a run")
  `RTP_ASSERT(a_div_no_restart, req.start |-> !busy_r, "divider started while busy")

endmodule

`default_nettype wire

>>> sv/rtp_back.sv
// Back end: parse state machine, header settings and the result register.
// Depends on rtp_pkg; drives rtp_div through div_req_t / div_rsp_t.
`default_nettype none

module rtp_back import rtp_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  output logic          q_pop,
  input  wire q_entry_t q_entry,
  output div_req_t      div_req,
  input  wire div_rsp_t div_rsp,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_t          out_data
);

  eng_state_t         state_r, state_nxt;
  div_dst_t           dst_r, dst_nxt;
  phase_t             phase_r, phase_nxt;
  key_t               key_r, key_nxt;
  logic [NUM_W-1:0]   acc_r, acc_nxt;
  logic [NUM_W-1:0]   def_len_r, def_len_nxt;
  logic [OCT_W-1:0]   def_oct_r, def_oct_nxt;
  logic [DUR_W-1:0]   whole_r, whole_nxt;
  logic [NOTE_W-1:0]  pnote_r, pnote_nxt;
  logic [DUR_W-1:0]   pdur_r, pdur_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic               take;
  logic               commit;
  logic               pending;
  logic [NUM_W-1:0]   note_div;
  logic [OCT_W-1:0]   note_oct;
  logic [DUR_W-1:0]   pdur_dot;

  assign take = (state_r == ENG_RUN) && q_valid && (!out_valid_r || !out_stall);
  assign q_pop = take;

  assign note_div = (acc_r != '0) ? acc_r :
                    (def_len_r != '0) ? def_len_r : NUM_W'(1);
  assign note_oct = ((phase_r inside {PH_NOCT, PH_NOCTDOT, PH_NDONE}) && acc_r != '0) ?
                    ((acc_r > OCT_SAT) ? OCT_W'(15) : acc_r[OCT_W-1:0]) : def_oct_r;
  assign pdur_dot = pdur_r + {1'b0, pdur_r[DUR_W-1:1]};
  assign pending  = (phase_r inside {PH_NLET, PH_NSHARP, PH_NDOT,
                                     PH_NOCT, PH_NOCTDOT, PH_NDONE});

  // next state of the division handshake
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ENG_RUN:  if (div_req.start) state_nxt = ENG_WAIT;
      ENG_WAIT: if (div_rsp.done)  state_nxt = ENG_RUN;
      default:  state_nxt = ENG_RUN;
    endcase
  end

  always_comb begin
    dst_nxt       = dst_r;
    phase_nxt     = phase_r;
    key_nxt       = key_r;
    acc_nxt       = acc_r;
    def_len_nxt   = def_len_r;
    def_oct_nxt   = def_oct_r;
    whole_nxt     = whole_r;
    pnote_nxt     = pnote_r;
    pdur_nxt      = pdur_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    commit        = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = whole_r;
    div_req.divisor  = note_div;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (state_r == ENG_WAIT && div_rsp.done) begin
      if (dst_r == DST_TEMPO) begin
        whole_nxt = {div_rsp.quotient[DUR_W-3:0], 2'b00};
      end else begin
        pdur_nxt = div_rsp.quotient;
      end
    end

    if (take) begin
      if (q_entry.restart) begin
        phase_nxt   = PH_NAME;
        key_nxt     = KEY_NONE;
        acc_nxt     = '0;
        def_len_nxt = DEF_LEN_RST;
        def_oct_nxt = DEF_OCT_RST;
        whole_nxt   = WHOLE_RST;
        pnote_nxt   = '0;
        pdur_nxt    = '0;
      end else if (q_entry.cls == CC_NUL && !pending) begin
        // terminator outside a note: end of song
        out_valid_nxt         = 1'b1;
        out_data_nxt          = '0;
        out_data_nxt.song_end = 1'b1;
        acc_nxt               = '0;
        key_nxt               = KEY_NONE;
        phase_nxt             = PH_END;
      end else if (pending) begin
        if (q_entry.cls == CC_NUL || q_entry.cls == CC_COMMA) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.note        = pnote_r;
          out_data_nxt.octave      = note_oct;
          out_data_nxt.duration_ms = pdur_r;
          out_data_nxt.song_end    = 1'b0;
          acc_nxt   = '0;
          pnote_nxt = '0;
          pdur_nxt  = '0;
          phase_nxt = (q_entry.cls == CC_NUL) ? PH_END : PH_NDUR;
        end else if (q_entry.cls == CC_HASH && phase_r == PH_NLET) begin
          pnote_nxt = pnote_r + NOTE_W'(1);
          phase_nxt = PH_NSHARP;
        end else if (q_entry.cls == CC_DOT) begin
          if (phase_r inside {PH_NLET, PH_NSHARP}) begin
            pdur_nxt  = pdur_dot;
            phase_nxt = PH_NDOT;
          end else if (phase_r == PH_NOCT) begin
            pdur_nxt  = pdur_dot;
            phase_nxt = PH_NDONE;
          end
        end else if (q_entry.cls == CC_DIGIT) begin
          if (phase_r inside {PH_NLET, PH_NSHARP}) begin
            acc_nxt   = NUM_W'(q_entry.digit);
            phase_nxt = PH_NOCT;
          end else if (phase_r == PH_NDOT) begin
            acc_nxt   = NUM_W'(q_entry.digit);
            phase_nxt = PH_NOCTDOT;
          end else if (phase_r inside {PH_NOCT, PH_NOCTDOT}) begin
            acc_nxt = add_digit(acc_r, q_entry.digit);
          end
        end
      end else begin
        case (phase_r)
          PH_NAME: begin
            if (q_entry.cls == CC_COLON) phase_nxt = PH_HKEY;
          end
          PH_HKEY, PH_HVAL: begin
            if (q_entry.cls == CC_COLON) begin
              commit    = 1'b1;
              phase_nxt = PH_NDUR;
            end else if (q_entry.cls == CC_COMMA) begin
              commit    = 1'b1;
              phase_nxt = PH_HKEY;
            end else if (phase_r == PH_HKEY) begin
              if (q_entry.key != KEY_NONE) begin
                key_nxt   = q_entry.key;
                phase_nxt = PH_HVAL;
              end
              acc_nxt = '0;
            end else if (q_entry.cls == CC_DIGIT && key_r != KEY_NONE) begin
              acc_nxt = add_digit(acc_r, q_entry.digit);
            end
          end
          PH_NDUR: begin
            if (q_entry.cls == CC_COMMA) begin
              acc_nxt = '0;
            end else if (q_entry.cls == CC_DIGIT) begin
              acc_nxt = add_digit(acc_r, q_entry.digit);
            end else if (q_entry.cls != CC_SPACE) begin
              // any other character opens a note; its length comes from the divider
              div_req.start    = 1'b1;
              div_req.dividend = whole_r;
              div_req.divisor  = note_div;
              dst_nxt          = DST_NOTE;
              pnote_nxt        = q_entry.letter;
              acc_nxt          = '0;
              phase_nxt        = PH_NLET;
            end
          end
          default: ;
        endcase
      end

      if (commit) begin
        case (key_r)
          KEY_D: if (acc_r != '0) def_len_nxt = acc_r;
          KEY_O: if (acc_r >= OCT_LO && acc_r <= OCT_HI) def_oct_nxt = acc_r[OCT_W-1:0];
          KEY_B: begin
            if (acc_r != '0) begin
              div_req.start    = 1'b1;
              div_req.dividend = MS_PER_MIN;
              div_req.divisor  = acc_r;
              dst_nxt          = DST_TEMPO;
            end
          end
          default: ;
        endcase
        key_nxt = KEY_NONE;
        acc_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ENG_RUN;
      dst_r       <= DST_NOTE;
      phase_r     <= PH_NAME;
      key_r       <= KEY_NONE;
      acc_r       <= '0;
      def_len_r   <= DEF_LEN_RST;
      def_oct_r   <= DEF_OCT_RST;
      whole_r     <= WHOLE_RST;
      pnote_r     <= '0;
      pdur_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dst_r       <= dst_nxt;
      phase_r     <= phase_nxt;
      key_r       <= key_nxt;
      acc_r       <= acc_nxt;
      def_len_r   <= def_len_nxt;
      def_oct_r   <= def_oct_nxt;
      whole_r     <= whole_nxt;
      pnote_r     <= pnote_nxt;
      pdur_r      <= pdur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "rtttl_note_parser_macros.svh"

  `RTP_ASSERT(a_start_enters_wait, div_req.start |=> state_r == ENG_WAIT,
              "division started but engine did not wait")
  `RTP_ASSERT(a_wait_tracks_divider, state_r == ENG_WAIT |-> div_rsp.busy || div_rsp.done,
              "engine waiting on an idle divider")

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for rtttl_note_parser: streams ringtone text words in and
// compares every note and song_end word with a built-in parser. Needs rtp_pkg.
module tb import rtp_pkg::*;;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam int unsigned TOP_NUM = 65535;
  localparam int unsigned RANDOM_WORDS = 1550;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  rtttl_note_parser uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  in_t  text_q[$];
  out_t tones_due[$];
  int unsigned in_gap = 0, out_hold = 0;
  int unsigned words_in = 0, restarts = 0, words_out = 0, notes_seen = 0, ends_seen = 0;
  int unsigned faults = 0;

  // Parser state as the block should hold it.
  phase_t ph;
  key_t hkey;
  int unsigned acc, def_len, def_oct, bpm, whole_ms, pend_note, pend_ms;

  function automatic void restart_song();
    ph = PH_NAME;
    hkey = KEY_NONE;
    acc = 0;
    def_len = 4;
    def_oct = 6;
    bpm = 63;
    whole_ms = 3808;
    pend_note = 0;
    pend_ms = 0;
  endfunction

  function automatic int unsigned push_digit(int unsigned a, logic [7:0] c);
    int unsigned v;
    v = a * 10 + (c - CH_0);
    return (v > TOP_NUM) ? TOP_NUM : v;
  endfunction

  function automatic bit close_song(output out_t r);
    r = '0;
    r.song_end = 1'b1;
    acc = 0;
    hkey = KEY_NONE;
    ph = PH_END;
    return 1'b1;
  endfunction

  function automatic void settle_header();
    if (hkey == KEY_D && acc > 0) begin
      def_len = acc;
    end else if (hkey == KEY_O && acc >= 3 && acc <= 7) begin
      def_oct = acc;
    end else if (hkey == KEY_B && acc > 0) begin
      bpm = acc;
      whole_ms = (60000 / bpm) * 4;
    end
    hkey = KEY_NONE;
    acc = 0;
  endfunction

  // Advance the parser by one text word; return 1 when a result word is due.
  function automatic bit parse_char(input in_t w, output out_t r);
    logic [7:0] c;
    bit dig;
    int unsigned dv, oct;
    c = w.ch;
    r = '0;
    dig = (c >= CH_0 && c <= CH_9);
    if (w.action) begin
      restart_song();
      return 1'b0;
    end
    case (ph)
      PH_NAME: begin
        if (c == CH_NUL) return close_song(r);
        if (c == CH_COLON) ph = PH_HKEY;
        return 1'b0;
      end
      PH_HKEY, PH_HVAL: begin
        if (c == CH_NUL) return close_song(r);
        if (c == CH_COLON) begin
          settle_header();
          ph = PH_NDUR;
        end else if (c == CH_COMMA) begin
          settle_header();
          ph = PH_HKEY;
        end else if (ph == PH_HKEY) begin
          if (c == "d") begin
            hkey = KEY_D;
            ph = PH_HVAL;
          end else if (c == "o") begin
            hkey = KEY_O;
            ph = PH_HVAL;
          end else if (c == "b") begin
            hkey = KEY_B;
            ph = PH_HVAL;
          end
          acc = 0;
        end else if (dig && hkey != KEY_NONE) begin
          acc = push_digit(acc, c);
        end
        return 1'b0;
      end
      PH_NDUR: begin
        if (c == CH_NUL) return close_song(r);
        if (c == CH_COMMA) begin
          acc = 0;
        end else if (dig) begin
          acc = push_digit(acc, c);
        end else if (c != CH_SPACE) begin
          dv = (acc > 0) ? acc : def_len;
          if (dv == 0) dv = 1;
          pend_ms = whole_ms / dv;
          case (c)
            "c": pend_note = 1;
            "d": pend_note = 3;
            "e": pend_note = 5;
            "f": pend_note = 6;
            "g": pend_note = 8;
            "a": pend_note = 10;
            "b": pend_note = 12;
            default: pend_note = 0;
          endcase
          acc = 0;
          ph = PH_NLET;
        end
        return 1'b0;
      end
      PH_END: begin
        if (c == CH_NUL) return close_song(r);
        return 1'b0;
      end
      default: ;
    endcase

    // a note is pending from here on
    if (c == CH_NUL || c == CH_COMMA) begin
      oct = def_oct;
      if ((ph == PH_NOCT || ph == PH_NOCTDOT || ph == PH_NDONE) && acc > 0)
        oct = (acc > 15) ? 15 : acc;
      r.note = 4'(pend_note);
      r.octave = 4'(oct);
      r.duration_ms = 19'(pend_ms);
      acc = 0;
      pend_note = 0;
      pend_ms = 0;
      ph = (c == CH_NUL) ? PH_END : PH_NDUR;
      return 1'b1;
    end
    if (c == CH_HASH && ph == PH_NLET) begin
      pend_note = (pend_note + 1) & 15;
      ph = PH_NSHARP;
    end else if (c == CH_DOT) begin
      if (ph == PH_NLET || ph == PH_NSHARP) begin
        pend_ms += pend_ms / 2;
        ph = PH_NDOT;
      end else if (ph == PH_NOCT) begin
        pend_ms += pend_ms / 2;
        ph = PH_NDONE;
      end
    end else if (dig) begin
      if (ph == PH_NLET || ph == PH_NSHARP) begin
        acc = push_digit(0, c);
        ph = PH_NOCT;
      end else if (ph == PH_NDOT) begin
        acc = push_digit(0, c);
        ph = PH_NOCTDOT;
      end else if (ph == PH_NOCT || ph == PH_NOCTDOT) begin
        acc = push_digit(acc, c);
      end
    end
    return 1'b0;
  endfunction

  // Every fourth stretch of 128 words runs without idling.
  function automatic int unsigned pause_len(int unsigned seq);
    return ((seq / 128) % 4 == 3) ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic void put(bit act, logic [7:0] c);
    in_t w;
    w.action = act;
    w.ch = c;
    text_q.push_back(w);
  endfunction

  function automatic void send_text(string s);
    for (int i = 0; i < s.len(); i++) put(1'b0, s[i]);
  endfunction

  function automatic void put_number(int unsigned v);
    if ($urandom_range(0, 11) == 0) put(1'b0, CH_0);
    send_text($sformatf("%0d", v));
  endfunction

  function automatic int unsigned note_len();
    case ($urandom_range(0, 15))
      0: return 0;
      1: return $urandom;
      2: return $urandom_range(1, 1000);
      default: return 1 << $urandom_range(0, 5);
    endcase
  endfunction

  function automatic int unsigned octave_pick();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return $urandom_range(8, 99);
      2: return $urandom;
      default: return $urandom_range(3, 7);
    endcase
  endfunction

  // One ringtone, mostly well formed, with the odd slip.
  task automatic queue_song();
    string letters;
    int unsigned n, i, kind;
    logic [7:0] c;
    letters = "cdefgabp";
    if ($urandom_range(0, 9) != 0) put(1'b1, 8'($urandom));
    n = $urandom_range(0, 4);
    for (i = 0; i < n; i++) begin
      c = 8'($urandom_range(1, 255));
      put(1'b0, (c == CH_COLON) ? 8'h7E : c);
    end
    if ($urandom_range(0, 29) == 0) begin
      put(1'b0, CH_NUL);
      return;
    end
    put(1'b0, CH_COLON);
    n = $urandom_range(0, 3);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) put(1'b0, CH_SPACE);
      kind = $urandom_range(0, 9);
      if (kind < 3) put(1'b0, "d");
      else if (kind < 6) put(1'b0, "o");
      else if (kind < 9) put(1'b0, "b");
      else put(1'b0, 8'($urandom_range(33, 126)));
      if ($urandom_range(0, 7) != 0) put(1'b0, CH_EQ);
      if ($urandom_range(0, 9) == 0) put(1'b0, CH_SPACE);
      if (kind < 3 || kind == 9) begin
        put_number(note_len());
      end else if (kind < 6) begin
        put_number(octave_pick());
      end else begin
        case ($urandom_range(0, 9))
          0: put_number(0);
          1: put_number($urandom);
          2: put_number($urandom_range(1, 20));
          default: put_number($urandom_range(25, 400));
        endcase
      end
      if (i + 1 < n) put(1'b0, CH_COMMA);
    end
    if ($urandom_range(0, 29) == 0) begin
      put(1'b0, CH_NUL);
      return;
    end
    put(1'b0, CH_COLON);
    n = $urandom_range(1, 8);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) put(1'b0, CH_SPACE);
      if ($urandom_range(0, 1) == 0) put_number(note_len());
      // otherwise leave the note empty
      if ($urandom_range(0, 11) != 0) begin
        if ($urandom_range(0, 9) != 0) begin
          c = letters[$urandom_range(0, 7)];
        end else begin
          c = 8'($urandom_range(33, 126));
          if ((c >= CH_0 && c <= CH_9) || c == CH_COMMA) c = "h";
        end
        put(1'b0, c);
        if ($urandom_range(0, 2) == 0) put(1'b0, CH_HASH);
        if ($urandom_range(0, 19) == 0) put(1'b0, CH_HASH);
        if ($urandom_range(0, 3) == 0) put(1'b0, CH_DOT);
        if ($urandom_range(0, 1) == 0) put_number(octave_pick());
        if ($urandom_range(0, 5) == 0) put(1'b0, CH_DOT);
        if ($urandom_range(0, 15) == 0) put_number($urandom_range(0, 9));
        if ($urandom_range(0, 19) == 0) put(1'b0, 8'($urandom_range(1, 255)));
        if ($urandom_range(0, 11) == 0) put(1'b0, CH_SPACE);
      end
      if (i + 1 < n) put(1'b0, CH_COMMA);
    end
    put(1'b0, CH_NUL);
    if ($urandom_range(0, 7) == 0) begin
      put(1'b0, 8'($urandom));
      put(1'b0, CH_NUL);
    end
  endtask

  // Feed text words; predict on every accepted word.
  always @(posedge clk) begin : char_feed
    out_t got;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        words_in++;
        if (in_data.action) restarts++;
        if (parse_char(in_data, got)) tones_due.push_back(got);
      end
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (text_q.size() != 0) begin
        in_data <= text_q.pop_front();
        in_valid <= 1'b1;
        in_gap <= pause_len(words_in);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Take result words, compare with the oldest prediction, then stall a while.
  always @(posedge clk) begin : result_check
    out_t want;
    int unsigned hold;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        words_out++;
        if (tones_due.size() == 0) begin
          $error("unexpected result word: note %0d octave %0d duration_ms %0d song_end %0b",
                 out_data.note, out_data.octave, out_data.duration_ms, out_data.song_end);
          faults++;
        end else begin
          want = tones_due.pop_front();
          if (out_data.note !== want.note) begin
            $error("note: expected %0d, got %0d", want.note, out_data.note);
            faults++;
          end
          if (out_data.octave !== want.octave) begin
            $error("octave: expected %0d, got %0d", want.octave, out_data.octave);
            faults++;
          end
          if (out_data.duration_ms !== want.duration_ms) begin
            $error("duration_ms: expected %0d, got %0d", want.duration_ms,
                   out_data.duration_ms);
            faults++;
          end
          if (out_data.song_end !== want.song_end) begin
            $error("song_end: expected %0b, got %0b", want.song_end, out_data.song_end);
            faults++;
          end
          if (want.song_end) ends_seen++;
          else notes_seen++;
        end
        hold = pause_len(words_out);
        out_stall <= (hold != 0);
        out_hold <= (hold == 0) ? 0 : hold - 1;
      end else if (out_hold != 0) begin
        out_stall <= 1'b1;
        out_hold <= out_hold - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    restart_song();
    // terminator in the name, then a short song touching most note forms
    put(1'b1, 8'hFF);
    put(1'b0, CH_NUL);
    put(1'b0, 8'hFF);
    put(1'b1, 8'h00);
    send_text(":o=7,d=32:16g#.4,x5");
    put(1'b0, CH_NUL);
    put(1'b0, CH_NUL);
    while (text_q.size() < 25 + RANDOM_WORDS) begin
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4)) put(1'($urandom), 8'($urandom));
      queue_song();
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (text_q.size() != 0 || in_valid || tones_due.size() != 0) @(negedge clk);
    // drain: a held word may still be inside the parser
    repeat (200) @(negedge clk);
    if (tones_due.size() != 0) begin
      $error("%0d result words never arrived", tones_due.size());
      faults++;
    end
    $display("Fed %0d text words (%0d restarts) through the parser.", words_in, restarts);
    $display("Checked %0d note words and %0d song_end words.", notes_seen, ends_seen);
    if (faults == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> rtttl_note_parser.f
+incdir+sv
sv/rtp_pkg.sv
sv/rtp_front.sv
sv/rtp_div.sv
sv/rtp_back.sv
sv/rtttl_note_parser.sv
bench/tb.sv
